// ===== rtl/nau_pkg.sv =====
package nau_pkg;

   // Beat field widths and default configuration
   localparam int VALUE_WIDTH       = 24;
   localparam int FRAC_BITS_DEF     = 16;
   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int GATE_WIDTH        = 2;

   // Leaky slope is LEAK_NUM / 2**LEAK_SHIFT
   localparam int LEAK_NUM   = 66;
   localparam int LEAK_SHIFT = 16;

   // Pipeline stages
   localparam int PIPE_STAGES = 4;
   localparam int ST_IN       = 0;
   localparam int ST_MUL      = 1;
   localparam int ST_WGT      = 2;
   localparam int ST_OUT      = 3;

   typedef enum logic [GATE_WIDTH-1:0] {
      GATE_SIGMOID = 2'd0,
      GATE_TANH    = 2'd1,
      GATE_RELU    = 2'd2,
      GATE_LEAKY   = 2'd3
   } gate_sel_type;

   typedef enum logic {
      ACT_APPLY = 1'b0,
      ACT_DERIV = 1'b1
   } action_type;

   typedef struct packed {
      action_type                     action;
      logic signed [VALUE_WIDTH-1:0] value;
   } req_beat_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] result;
      logic                          saturated;
   } rsp_beat_type;

   typedef struct packed {
      logic [PIPE_STAGES-1:0] load;
      logic [PIPE_STAGES-1:0] valid;
   } pipe_ctl_type;

   // Restoring long division, evaluated only while building constants
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Sigmoid at x_k = -8 + 16k/n in Q(frac): e^u by Taylor sum in Q40,
   // reciprocal in Q30, four squarings give e^-|x_k|.
   function automatic logic [63:0] sig_point(input int k, input int n, input int frac);
      logic [63:0] j;
      logic [63:0] n2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] e30;
      logic [63:0] p;
      logic [63:0] den;
      logic [63:0] num;
      n2 = 64'(2 * n);
      j  = (2 * k >= n) ? 64'(2 * k - n) : 64'(n - 2 * k);
      term = 64'd1 << 40;
      sum  = term;
      for (int m = 1; m <= 20; m++) begin
         term = udiv64(term * j, n2 * 64'(m));
         sum  = sum + term;
      end
      e30 = (sum + (64'd1 << 9)) >> 10;
      p   = udiv64((64'd1 << 60) + (e30 >> 1), e30);
      for (int s = 0; s < 4; s++) begin
         p = (p * p + (64'd1 << 29)) >> 30;
      end
      den = (64'd1 << 30) + p;
      num = (2 * k < n) ? p : (64'd1 << 30);
      return udiv64((num << frac) + (den >> 1), den);
   endfunction

endpackage

// ===== rtl/neural_activation_unit.sv =====
// Activation unit in signed fixed point (VALUE_WIDTH bits, FRAC_BITS fraction bits, Q8.16 by
// default). csr_data written with csr_write picks sigmoid, tanh, relu or leaky relu (slope
// 66/65536). A request beat with action apply gives the activation of value; with action deriv
// it takes an already activated value a and gives a(1-a), 1-a*a, a step 0/1 or a step
// 0.001/1. Sigmoid comes from a constant table of TABLE_ENTRIES+1 points over [-8,8] with
// linear interpolation, and clamps outside; tanh is 2*sigmoid(2x)-1. Results round to nearest
// (halves up) and saturate, with saturated flagging a clamp. The unit takes one beat per clock
// while rsp_stall does not hold it back, and presents each result on rsp_beat from the output
// register; a beat passes four register stages (input, range and multiply, table weighting,
// output), and each stage advances on its own, so a stalled output holds only the beats
// behind it. Write gate_type only while no beat is in flight.
module neural_activation_unit #(
   parameter int FRAC_BITS     = nau_pkg::FRAC_BITS_DEF,
   parameter int TABLE_ENTRIES = nau_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  nau_pkg::req_beat_type           req_beat,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output nau_pkg::rsp_beat_type           rsp_beat,
   input  logic                            csr_write,
   input  logic [nau_pkg::GATE_WIDTH-1:0]  csr_data
);
   import nau_pkg::*;

   localparam int W    = VALUE_WIDTH;
   localparam int SPAN = FRAC_BITS + 4;                      // table span is 16 in Q(F)
   localparam int CW   = (W + 2 > SPAN + 1) ? W + 2 : SPAN + 1;
   localparam int NB   = $clog2(TABLE_ENTRIES + 1);
   localparam int PW   = SPAN + NB;
   localparam int TW   = FRAC_BITS + 1;
   localparam int IPW  = 2 * FRAC_BITS + 6;
   localparam int MW   = ((W > FRAC_BITS + 1) ? W : FRAC_BITS + 1) + 2;
   localparam int PRW  = W + MW;
   localparam int QW   = ((PRW > 2 * FRAC_BITS + 2) ? PRW : 2 * FRAC_BITS + 2) + 1;
   localparam int LEAK_D = ((LEAK_NUM << FRAC_BITS) + (1 << (LEAK_SHIFT - 1))) >>> LEAK_SHIFT;

   localparam logic signed [CW-1:0] EIGHT_C = CW'(8) <<< FRAC_BITS;
   localparam logic signed [MW-1:0] ONE_M   = MW'(1) <<< FRAC_BITS;
   localparam logic signed [QW-1:0] ONE_Q   = QW'(1) <<< FRAC_BITS;
   localparam logic signed [QW-1:0] HALF_Q  = QW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [QW-1:0] SQ_Q    = QW'(1) <<< (2 * FRAC_BITS);
   localparam logic signed [QW-1:0] HALF_LK = QW'(1) <<< (LEAK_SHIFT - 1);
   localparam logic signed [QW-1:0] MAX_Q   = (QW'(1) <<< (W - 1)) - QW'(1);
   localparam logic signed [QW-1:0] MIN_Q   = -(QW'(1) <<< (W - 1));
   localparam logic [IPW:0]         HALF_S  = (IPW + 1)'(1) << (SPAN - 1);

   pipe_ctl_type ctl;
   gate_sel_type gate_type_ff;
   gate_sel_type gate_type_in;

   // Input stage
   action_type          act1_ff;
   logic signed [W-1:0] x1_ff;

   // Range and multiply stage
   logic signed [CW-1:0]  xs;
   logic signed [CW-1:0]  off_c;
   logic signed [MW-1:0]  mb;
   action_type            act2_ff;
   logic signed [W-1:0]   x2_ff;
   logic [PW-1:0]         pos2_ff;
   logic [PW-1:0]         pos2_in;
   logic                  lo2_ff;
   logic                  lo2_in;
   logic                  hi2_ff;
   logic                  hi2_in;
   logic signed [PRW-1:0] prod2_ff;
   logic signed [PRW-1:0] prod2_in;

   // Table weighting stage
   logic [NB-1:0]         idx_sel;
   logic [SPAN-1:0]       rem_sel;
   logic [IPW-1:0]        pa3_in;
   logic [IPW-1:0]        pb3_in;
   logic [IPW-1:0]        pa3_ff;
   logic [IPW-1:0]        pb3_ff;
   logic signed [QW-1:0]  qp;
   logic                  x_neg;
   logic signed [QW-1:0]  dir3_in;
   logic signed [QW-1:0]  dir3_ff;
   logic                  use_sig3_in;
   logic                  use_sig3_ff;

   // Output stage
   logic [IPW:0]          vsum;
   logic [TW-1:0]         sig;
   logic signed [QW-1:0]  sig_q;
   logic signed [QW-1:0]  rval;
   rsp_beat_type          rsp_in;
   rsp_beat_type          rsp_ff;

   nau_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .out_stall (rsp_stall),
      .ctl       (ctl)
   );

   // Gate select register; it is to be written only while the pipeline is empty, which the block does not enforce
   assign gate_type_in = csr_write ? gate_sel_type'(csr_data) : gate_type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_type_ff <= GATE_SIGMOID;
      end else begin
         gate_type_ff <= gate_type_in;
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (ctl.load[ST_IN]) begin
         act1_ff <= req_beat.action;
         x1_ff   <= req_beat.value;
      end
   end

   // Tanh looks up sigmoid at 2x, formed at least two bits wider so it cannot wrap. Range flags decide
   // clamping; inside the range pos = (x + 8) * N, whose upper bits are the table index and
   // lower bits the interpolation weight. The one multiplier serves both derivative products
   // and the leaky slope.
   always_comb begin
      xs       = (gate_type_ff == GATE_TANH) ? (CW'(x1_ff) <<< 1) : CW'(x1_ff);
      lo2_in   = xs < -EIGHT_C;
      hi2_in   = xs >= EIGHT_C;
      off_c    = xs + EIGHT_C;
      pos2_in  = PW'(off_c[SPAN-1:0]) * PW'(TABLE_ENTRIES);
      if (act1_ff == ACT_DERIV) begin
         mb = (gate_type_ff == GATE_TANH) ? MW'(x1_ff) : ONE_M - MW'(x1_ff);
      end else begin
         mb = MW'(LEAK_NUM);
      end
      prod2_in = PRW'(x1_ff) * PRW'(mb);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[ST_MUL]) begin
         act2_ff  <= act1_ff;
         x2_ff    <= x1_ff;
         pos2_ff  <= pos2_in;
         lo2_ff   <= lo2_in;
         hi2_ff   <= hi2_in;
         prod2_ff <= prod2_in;
      end
   end

   // Clamp to the end points with zero weight on the neighbor
   always_comb begin
      if (lo2_ff) begin
         idx_sel = '0;
      end else if (hi2_ff) begin
         idx_sel = NB'(TABLE_ENTRIES);
      end else begin
         idx_sel = pos2_ff[PW-1:SPAN];
      end
      rem_sel = (lo2_ff || hi2_ff) ? '0 : pos2_ff[SPAN-1:0];
   end

   nau_sig_lut #(
      .FRAC_BITS     (FRAC_BITS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_lut (
      .idx     (idx_sel),
      .rem     (rem_sel),
      .prod_lo (pa3_in),
      .prod_hi (pb3_in)
   );

   // Every result that does not go through the table finishes here
   always_comb begin
      qp          = QW'(prod2_ff);
      x_neg       = x2_ff[W-1];
      use_sig3_in = (act2_ff == ACT_APPLY) &&
                    (gate_type_ff == GATE_SIGMOID || gate_type_ff == GATE_TANH);
      dir3_in     = '0;
      if (act2_ff == ACT_APPLY) begin
         unique case (gate_type_ff) inside
            GATE_SIGMOID, GATE_TANH: dir3_in = '0;
            GATE_RELU:               dir3_in = x_neg ? '0 : QW'(x2_ff);
            GATE_LEAKY:              dir3_in = x_neg ? (qp + HALF_LK) >>> LEAK_SHIFT
                                                     : QW'(x2_ff);
         endcase
      end else begin
         unique case (gate_type_ff)
            GATE_SIGMOID: dir3_in = (qp + HALF_Q) >>> FRAC_BITS;
            GATE_TANH:    dir3_in = (SQ_Q - qp + HALF_Q) >>> FRAC_BITS;
            GATE_RELU:    dir3_in = x_neg ? '0 : ONE_Q;
            GATE_LEAKY:   dir3_in = x_neg ? QW'(LEAK_D) : ONE_Q;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[ST_WGT]) begin
         pa3_ff      <= pa3_in;
         pb3_ff      <= pb3_in;
         dir3_ff     <= dir3_in;
         use_sig3_ff <= use_sig3_in;
      end
   end

   // Sum the weighted points, round, fold tanh, then saturate
   always_comb begin
      vsum  = (IPW + 1)'(pa3_ff) + (IPW + 1)'(pb3_ff) + HALF_S;
      sig   = vsum[SPAN +: TW];
      sig_q = signed'(QW'(sig));
      if (!use_sig3_ff) begin
         rval = dir3_ff;
      end else if (gate_type_ff == GATE_TANH) begin
         rval = (sig_q <<< 1) - ONE_Q;
      end else begin
         rval = sig_q;
      end
      if (rval > MAX_Q) begin
         rsp_in.result    = MAX_Q[W-1:0];
         rsp_in.saturated = 1'b1;
      end else if (rval < MIN_Q) begin
         rsp_in.result    = MIN_Q[W-1:0];
         rsp_in.saturated = 1'b1;
      end else begin
         rsp_in.result    = rval[W-1:0];
         rsp_in.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[ST_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_beat  = rsp_ff;
   assign rsp_valid = ctl.valid[ST_OUT];

endmodule

// ===== rtl/nau_sig_lut.sv =====
module nau_sig_lut #(
   parameter int FRAC_BITS     = nau_pkg::FRAC_BITS_DEF,
   parameter int TABLE_ENTRIES = nau_pkg::TABLE_ENTRIES_DEF
) (
   input  logic [$clog2(TABLE_ENTRIES+1)-1:0] idx,
   input  logic [FRAC_BITS+3:0]               rem,
   output logic [2*FRAC_BITS+5:0]             prod_lo,
   output logic [2*FRAC_BITS+5:0]             prod_hi
);
   import nau_pkg::*;

   localparam int NB   = $clog2(TABLE_ENTRIES + 1);
   localparam int TW   = FRAC_BITS + 1;
   localparam int SPAN = FRAC_BITS + 4;
   localparam int PW   = 2 * FRAC_BITS + 6;
   localparam logic [SPAN:0] SPAN_W = (SPAN + 1)'(1) << SPAN;

   logic [TW-1:0] tab [TABLE_ENTRIES+1];
   logic [NB-1:0] idx_nx;
   logic [SPAN:0] wgt_lo;

   for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_point
      localparam logic [63:0] POINT = sig_point(k, TABLE_ENTRIES, FRAC_BITS);
      assign tab[k] = POINT[TW-1:0];
   end

   // Hold the upper neighbor at the last point; its weight is zero there
   assign idx_nx = (idx == NB'(TABLE_ENTRIES)) ? idx : idx + 1'b1;
   assign wgt_lo = SPAN_W - (SPAN + 1)'(rem);

   assign prod_lo = PW'(tab[idx])    * PW'(wgt_lo);
   assign prod_hi = PW'(tab[idx_nx]) * PW'(rem);

endmodule

// ===== rtl/nau_pipe_ctl.sv =====
module nau_pipe_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  logic                  out_stall,
   output nau_pkg::pipe_ctl_type ctl
);
   import nau_pkg::*;

   localparam int LAST = PIPE_STAGES - 1;

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES-1:0] ready;
   logic [PIPE_STAGES-1:0] drain;
   logic [PIPE_STAGES-1:0] load;
   logic                   in_take;
   logic                   out_take;

   // A stage takes a beat when empty or when its own beat moves on
   always_comb begin
      ready[LAST] = !valid_ff[LAST] || !out_stall;
      drain[LAST] = valid_ff[LAST] && !out_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
         drain[i] = valid_ff[i] && ready[i+1];
      end
      load[0] = in_valid && ready[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         load[i] = drain[i-1];
      end
      valid_in = load | (valid_ff & ~drain);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_stall  = !ready[0];
   assign in_take   = load[0];
   assign out_take  = drain[LAST];
   assign ctl.load  = load;
   assign ctl.valid = valid_ff;

   a_beat_count : assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> ($countones(valid_ff) == $past($countones(valid_ff))
         + $past(32'(in_take)) - $past(32'(out_take))))
      else $error("beat count in pipeline does not match beats taken and delivered");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && out_stall) |-> in_stall)
      else $error("input not stalled while pipeline is full and output stalled");

   a_empty_take : assert property (@(posedge clock) disable iff (reset)
      !valid_ff[ST_IN] |-> !in_stall)
      else $error("input stalled while first stage is empty");

endmodule

// ===== sim/neural_activation_unit_tb.sv =====
module neural_activation_unit_tb;
   import nau_pkg::*;

   localparam int FRAC       = FRAC_BITS_DEF;
   localparam int TABLE_N    = TABLE_ENTRIES_DEF;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_OFF   = 150;
   localparam int RANDOM_PHASES     = 8;
   localparam int BEATS_PER_PHASE   = 112;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_beat_type          req_beat  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_beat_type          rsp_beat;
   logic                  csr_write = 1'b0;
   logic [GATE_WIDTH-1:0] csr_data  = '0;

   neural_activation_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat),
      .csr_write (csr_write),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Sigmoid knots over [-8,8] in Q(FRAC), filled once at time zero
   longint sigmoid_knots [0:TABLE_N];

   // Traffic bookkeeping
   req_beat_type beat_backlog[$];     // beats waiting for the driver
   rsp_beat_type pending_results[$];  // predicted results, oldest first
   gate_sel_type gate_model;          // mirror of gate_type
   int           beats_queued   = 0;
   int           beats_accepted = 0;
   int           results_seen   = 0;
   int           error_count    = 0;
   int           idle_cycles    = 0;
   bit           req_took       = 1'b0;

   // Idle behavior: 0 never idles, 1 light, 2 heavy
   int sender_mode   = 0;
   int receiver_mode = 0;
   int hold_requests = 0;
   int hold_served   = 0;

   // Knot k sits at -8 + 16k/N: e^u by Taylor sum in Q40, reciprocal in Q30,
   // four squarings yield e^-|x|, then the logistic ratio.
   function automatic longint knot_at(int k);
      longint unsigned steps, term, sum, e30, p, den, num;
      steps = (2 * k >= TABLE_N) ? 2 * k - TABLE_N : TABLE_N - 2 * k;
      term = 64'd1 << 40;
      sum  = term;
      for (int n = 1; n <= 20; n++) begin
         term = term * steps / (64'(2 * TABLE_N) * 64'(n));
         sum  = sum + term;
      end
      e30 = (sum + (64'd1 << 9)) >> 10;
      p   = ((64'd1 << 60) + e30 / 2) / e30;
      for (int s = 0; s < 4; s++) begin
         p = (p * p + (64'd1 << 29)) >> 30;
      end
      den = (64'd1 << 30) + p;
      num = (2 * k < TABLE_N) ? p : (64'd1 << 30);
      return longint'(((num << FRAC) + den / 2) / den);
   endfunction

   // Round to nearest with halves up: a floor shift of the biased value
   function automatic longint round_shift_up(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   // Interpolated sigmoid, clamped to the end knots outside [-8,8)
   function automatic longint sigmoid_q(longint x);
      longint eight, span, pos, idx, frac_pos;
      eight = longint'(8) << FRAC;
      span  = longint'(16) << FRAC;
      if (x < -eight) return sigmoid_knots[0];
      if (x >= eight) return sigmoid_knots[TABLE_N];
      pos      = (x + eight) * TABLE_N;
      idx      = pos / span;
      frac_pos = pos % span;
      if (idx >= TABLE_N) return sigmoid_knots[TABLE_N];
      return (sigmoid_knots[idx] * (span - frac_pos)
              + sigmoid_knots[idx + 1] * frac_pos + span / 2) / span;
   endfunction

   // Expected result of one request beat under the given gate
   function automatic rsp_beat_type activation_of(gate_sel_type g, req_beat_type b);
      rsp_beat_type out;
      longint x, r, one, maxv, minv;
      x    = b.value;
      one  = longint'(1) << FRAC;
      maxv = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
      minv = -maxv - 1;
      if (b.action == ACT_APPLY) begin
         case (g)
            GATE_SIGMOID: r = sigmoid_q(x);
            GATE_TANH:    r = 2 * sigmoid_q(2 * x) - one;
            GATE_RELU:    r = (x < 0) ? 0 : x;
            default:      r = (x < 0) ? round_shift_up(x * LEAK_NUM, LEAK_SHIFT) : x;
         endcase
      end else begin
         case (g)
            GATE_SIGMOID: r = round_shift_up(x * (one - x), FRAC);
            GATE_TANH:    r = round_shift_up((longint'(1) << (2 * FRAC)) - x * x, FRAC);
            GATE_RELU:    r = (x < 0) ? 0 : one;
            default:      r = (x < 0) ? round_shift_up(longint'(LEAK_NUM) << FRAC, LEAK_SHIFT)
                                      : one;
         endcase
      end
      out.saturated = 1'b0;
      if (r > maxv) begin
         r = maxv;
         out.saturated = 1'b1;
      end
      if (r < minv) begin
         r = minv;
         out.saturated = 1'b1;
      end
      out.result = r[VALUE_WIDTH-1:0];
      return out;
   endfunction

   // Idle length: none in mode 0; otherwise none, short or long, with more idles in mode 2
   function automatic int gap_draw(int mode);
      int p;
      p = $urandom_range(0, 99);
      if (mode == 0) return 0;
      if (p < ((mode == 1) ? 70 : 40)) return 0;
      if (p < ((mode == 1) ? 95 : 85)) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   // Random operand: most in the interesting range of each function, the rest
   // on table knots, anywhere in the field, or against its limits
   function automatic req_beat_type random_beat();
      req_beat_type b;
      logic signed [VALUE_WIDTH-1:0] v;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         v = VALUE_WIDTH'($urandom_range(0, 18 << 16) - (9 << 16));
      else if (pick < 55)
         v = VALUE_WIDTH'($urandom_range(0, 5 << 15) - (5 << 14));
      else if (pick < 70)
         v = VALUE_WIDTH'(($urandom_range(0, TABLE_N) << (FRAC - 4)) - (8 << FRAC)
                          + $urandom_range(0, 4) - 2);
      else if (pick < 85)
         v = VALUE_WIDTH'($urandom);
      else if ($urandom_range(0, 1))
         v = VALUE_WIDTH'(VALUE_MIN + $urandom_range(0, 15));
      else
         v = VALUE_WIDTH'(VALUE_MAX - $urandom_range(0, 15));
      b.action = action_type'($urandom_range(0, 1));
      b.value  = v;
      return b;
   endfunction

   task automatic queue_beat(req_beat_type b);
      beat_backlog.push_back(b);
      beats_queued++;
   endtask

   task automatic queue_directed(action_type a, logic signed [VALUE_WIDTH-1:0] v);
      req_beat_type b;
      b.action = a;
      b.value  = v;
      queue_beat(b);
   endtask

   // Hold until every queued beat went in and every prediction came back
   task automatic wait_drained();
      @(negedge clock);
      while (beats_accepted != beats_queued || pending_results.size() != 0)
         @(negedge clock);
   endtask

   // Drain, optionally rewrite gate_type, then release the next batch on a
   // rising edge so the driver sees it cleanly at the following falling edge
   task automatic start_phase(bit do_write, gate_sel_type g, int s_mode, int r_mode);
      wait_drained();
      if (do_write) begin
         csr_write <= 1'b1;
         csr_data  <= g;
         @(negedge clock);
         csr_write <= 1'b0;
      end
      @(posedge clock);
      sender_mode   = s_mode;
      receiver_mode = r_mode;
   endtask

   // Driver: present a beat, hold it until taken, then idle or advance
   always @(negedge clock) begin
      req_beat_type next_beat;
      logic         next_valid;
      static int    gap_left = 0;
      next_valid = req_valid;
      next_beat  = req_beat;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_took) begin
         if (gap_left > 0) begin
            next_valid = 1'b0;
            gap_left--;
         end else if (beat_backlog.size() > 0) begin
            next_beat  = beat_backlog.pop_front();
            next_valid = 1'b1;
            gap_left   = gap_draw(sender_mode);
         end else begin
            next_valid = 1'b0;
         end
      end
      req_valid <= next_valid;
      req_beat  <= next_beat;
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested
   always @(negedge clock) begin
      logic      next_stall;
      static int hold_left = 0;
      static int stall_left = 0;
      if (reset) begin
         next_stall = 1'b0;
      end else if (hold_left > 0) begin
         next_stall = 1'b1;
         hold_left--;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left  = HOLD_OFF - 1;
         next_stall = 1'b1;
      end else if (stall_left > 0) begin
         next_stall = 1'b1;
         stall_left--;
      end else begin
         next_stall = 1'b0;
         stall_left = gap_draw(receiver_mode);
      end
      rsp_stall <= next_stall;
   end

   // Monitor: predict on each accepted request, check each accepted result,
   // and end the run if traffic stops moving
   always @(posedge clock) begin
      rsp_beat_type want;
      bit           moved;
      moved    = 1'b0;
      req_took = 1'b0;
      if (reset) begin
         gate_model  = GATE_SIGMOID;
         idle_cycles = 0;
      end else begin
         if (csr_write) gate_model = gate_sel_type'(csr_data);
         if (req_valid && !req_stall) begin
            pending_results.push_back(activation_of(gate_model, req_beat));
            beats_accepted++;
            req_took = 1'b1;
            moved    = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (pending_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: result %0d sat %0b arrived with nothing expected",
                           rsp_beat.result, rsp_beat.saturated);
            end else begin
               want = pending_results.pop_front();
               if (rsp_beat.result !== want.result || rsp_beat.saturated !== want.saturated) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("ERROR: result %0d: expected %0d sat %0b, got %0d sat %0b",
                              results_seen, want.result, want.saturated,
                              rsp_beat.result, rsp_beat.saturated);
               end
            end
            results_seen++;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      for (int k = 0; k <= TABLE_N; k++)
         sigmoid_knots[k] = knot_at(k);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: each gate with both actions at the field limits, the first
      // under the reset value of gate_type; -1 exercises leaky rounding and
      // 8.0 the upper table clamp, sigmoid and tanh derivatives at the limits saturate
      for (int g = 0; g < 4; g++) begin
         start_phase(g != 0, gate_sel_type'(g), 0, 0);
         queue_directed(ACT_APPLY, VALUE_MIN);
         queue_directed(ACT_APPLY, VALUE_MAX);
         queue_directed(ACT_APPLY, VALUE_WIDTH'(-1));
         queue_directed(ACT_APPLY, VALUE_WIDTH'(8 << FRAC));
         queue_directed(ACT_DERIV, VALUE_MIN);
         queue_directed(ACT_DERIV, VALUE_MAX);
      end

      // Random: every gate in turn, then random gates; idling varies by phase
      // and one phase runs flat out against a long receiver hold-off so the
      // pipeline fills and pushes back on the sender
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         start_phase(1'b1,
                     (p < 4) ? gate_sel_type'((3 + p) % 4) : gate_sel_type'($urandom_range(0, 3)),
                     (p == 1) ? 0 : p % 3, (p + 1) % 3);
         for (int i = 0; i < BEATS_PER_PHASE; i++)
            queue_beat(random_beat());
         if (p == 1) hold_requests++;
      end

      wait_drained();
      repeat (2 * PIPE_STAGES) @(negedge clock);
      error_count += pending_results.size();
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== neural_activation_unit.f =====
rtl/nau_pkg.sv
rtl/nau_sig_lut.sv
rtl/nau_pipe_ctl.sv
rtl/neural_activation_unit.sv
sim/neural_activation_unit_tb.sv
